// ===== src/btk_pkg.sv =====
// ----------------------------------------------------------------------------
// btk_pkg
// Shared types and constants for the bounded sorted top-k insertion core.
// ----------------------------------------------------------------------------
package btk_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam int IN_RAW_W   = KEY_W + VAL_W + IDX_W;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 1 + CNT_W + 1 + KEY_W + VAL_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_DESCENDING = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY   = CFG_ADDR_W'(1);

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic commit;
    logic desc;
    logic held;
  } cell_ctl_t;

  typedef struct packed {
    logic flag;
    logic hit;
    logic dup;
  } cell_st_t;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(DEPTH)) begin
      r = CNT_W'(DEPTH);
    end
    return r;
  endfunction

endpackage

// ===== src/btk_cell.sv =====
// ----------------------------------------------------------------------------
// btk_cell
// One slot of the sorted table: compares the broadcast key with its own entry
// and on insert keeps, loads the new entry, or takes its left neighbor's.
// ----------------------------------------------------------------------------
module btk_cell
  import btk_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_flag,
  output entry_t    entry,
  output cell_st_t  st
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   ranks;

  always_comb begin
    ranks   = ctl.desc ? (new_entry.key >= entry_r.key) : (new_entry.key <= entry_r.key);
    st.hit  = ctl.held && ranks;
    st.dup  = ctl.held && (new_entry.key == entry_r.key);
    st.flag = !ctl.held || ranks;
    entry_nxt = entry_r;
    if (ctl.commit) begin
      if (left_flag) begin
        entry_nxt = left_entry;
      end else if (st.flag) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== src/bounded_sorted_topk_insert_core.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_topk_insert_core
// Keeps the best distinct signed keys with values in a sorted row of cells.
// ----------------------------------------------------------------------------
// Takes one transaction per clock. A push compares its key against every cell
// of the row at once and inserts, shifts and drops the tail in that same
// cycle, so the next transaction already sees the updated table; the result
// is captured in the output register on acceptance. Input is held off only
// while that output register is full and not being taken. Configuration
// writes are to go in while the core is idle; the core does not enforce it.
// Changing the order empties the table, lowering the capacity trims it.
module bounded_sorted_topk_insert_core
  import btk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key, value, index, zero pad
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // accepted, count, entry_valid,
                                            // entry_key, entry_value, zero pad
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                  desc_r;
  logic [CNT_W-1:0]      cap_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [OUT_RAW_W-1:0]  out_data_r;
  logic [OUT_RAW_W-1:0]  out_data_nxt;

  entry_t                new_entry;
  logic [IDX_W-1:0]      in_index;
  logic                  in_fire;
  logic                  is_push;
  logic                  hit_any;
  logic                  dup_any;
  logic                  full;
  logic                  push_ok;
  logic                  commit;
  logic                  rd_valid;
  entry_t                rd_entry;
  entry_t                rd_out;

  entry_t                cell_q [DEPTH];
  cell_st_t              cell_st [DEPTH];
  cell_ctl_t             cell_ctl [DEPTH];

  assign new_entry.key   = in_tdata[KEY_W-1:0];
  assign new_entry.value = in_tdata[KEY_W+VAL_W-1:KEY_W];
  assign in_index        = in_tdata[IN_RAW_W-1:KEY_W+VAL_W];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_push   = (in_tuser == FUNC_PUSH);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign cell_ctl[g].commit = commit;
      assign cell_ctl[g].desc   = desc_r;
      assign cell_ctl[g].held   = (CNT_W'(g) < count_r);
      if (g == 0) begin : g_head
        btk_cell u_cell (
          .clk        (clk),
          .ctl        (cell_ctl[g]),
          .new_entry  (new_entry),
          .left_entry (new_entry),
          .left_flag  (1'b0),
          .entry      (cell_q[g]),
          .st         (cell_st[g])
        );
      end else begin : g_body
        btk_cell u_cell (
          .clk        (clk),
          .ctl        (cell_ctl[g]),
          .new_entry  (new_entry),
          .left_entry (cell_q[g-1]),
          .left_flag  (cell_st[g-1].flag),
          .entry      (cell_q[g]),
          .st         (cell_st[g])
        );
      end
    end
  endgenerate

  always_comb begin
    hit_any  = 1'b0;
    dup_any  = 1'b0;
    rd_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_any = hit_any | cell_st[i].hit;
      dup_any = dup_any | cell_st[i].dup;
      if (CNT_W'(i) == CNT_W'(in_index)) begin
        rd_entry = cell_q[i];
      end
    end
  end

  always_comb begin
    full     = (count_r >= cap_r);
    push_ok  = !dup_any && (hit_any || !full);
    commit   = in_fire && is_push && push_ok;
    rd_valid = !is_push && (CNT_W'(in_index) < count_r);
    count_nxt = count_r;
    if (commit && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    rd_out = rd_entry;
    if (!rd_valid) begin
      rd_out = '0;
    end
    out_data_nxt = {rd_out.value, rd_out.key, rd_valid, count_nxt, commit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r      <= 1'b0;
      cap_r       <= clamp_cap(CAP_RESET);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          CFG_DESCENDING: begin
            desc_r  <= cfg_wdata[0];
            count_r <= '0;
          end
          CFG_CAPACITY: begin
            cap_r <= clamp_cap(cfg_wdata);
            if (count_r > clamp_cap(cfg_wdata)) begin
              count_r <= clamp_cap(cfg_wdata);
            end
          end
          default: begin
          end
        endcase
      end else if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, out_data_r};

endmodule

// ===== src/btk_checker.sv =====
// ----------------------------------------------------------------------------
// btk_checker
// Port-level checks for the top-k insertion core, bound to the top level.
// ----------------------------------------------------------------------------
module btk_checker
  import btk_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic                    r_accepted;
  logic [CNT_W-1:0]        r_count;
  logic                    r_valid;
  logic [KEY_W+VAL_W-1:0]  r_payload;

  assign r_accepted = out_tdata[0];
  assign r_count    = out_tdata[CNT_W:1];
  assign r_valid    = out_tdata[CNT_W+1];
  assign r_payload  = out_tdata[OUT_RAW_W-1:CNT_W+2];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted transaction produced no result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> r_count <= CNT_W'(DEPTH))
    else $error("count beyond table depth");

  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(r_accepted && r_valid))
    else $error("result flags both push and read");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !r_valid |-> r_payload == '0)
    else $error("entry fields nonzero without a valid entry");

endmodule

bind bounded_sorted_topk_insert_core btk_checker u_btk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded sorted top-k insertion core.
// ----------------------------------------------------------------------------
// A driver sends push and read transactions from a pending queue, and a
// monitor compares each result with a software table kept in step at
// acceptance. A directed opening covers empty-table reads, key 0,
// duplicates, extreme keys, full-table rejects and out-of-range capacities.
// Random phases then change the sort order and the capacity while the core
// is idle. Both sides stall at random, with two long receiver holds.
// ----------------------------------------------------------------------------
module tb_top;
  import btk_pkg::*;

  typedef struct packed {
    logic                    func;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } topk_item_t;

  typedef struct packed {
    logic                    accepted;
    logic [CNT_W-1:0]        count;
    logic                    entry_valid;
    logic signed [KEY_W-1:0] entry_key;
    logic signed [VAL_W-1:0] entry_value;
  } topk_result_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // key, value, index, zero pad
  logic                  in_tuser   = 1'b0; // func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // accepted, count, entry_valid,
                                            // entry_key, entry_value, zero pad
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  bounded_sorted_topk_insert_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // software copy of the table
  logic signed [KEY_W-1:0] tbl_key [DEPTH];
  logic signed [VAL_W-1:0] tbl_val [DEPTH];
  int                      tbl_cnt   = 0;
  bit                      order_desc = 1'b0;
  logic [CNT_W-1:0]        cap_reg   = CAP_RESET;

  topk_item_t   pend_q[$];
  topk_result_t topk_expect_q[$];
  topk_item_t   tx_item;
  int           tx_gap        = 0;
  int           rx_hold       = 0;
  int           items_queued  = 0;
  int           items_taken   = 0;
  int           results_seen  = 0;
  int           err_cnt       = 0;
  bit           tx_gap_en     = 1'b1;
  bit           rx_gap_en     = 1'b1;

  function automatic int eff_cap();
    if (cap_reg == '0) return 1;
    if (cap_reg > CNT_W'(DEPTH)) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic bit ranks_first(input logic signed [KEY_W-1:0] a,
                                     input logic signed [KEY_W-1:0] b);
    return order_desc ? (a >= b) : (a <= b);
  endfunction

  function automatic topk_result_t apply_item(input topk_item_t it);
    topk_result_t r;
    int           cap;
    int           n;
    int           pos;
    bit           found;
    r = '0;
    if (it.func == FUNC_PUSH) begin
      cap = eff_cap();
      n = (tbl_cnt > cap) ? cap : tbl_cnt;
      pos = n;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!found && ranks_first(it.key, tbl_key[i])) begin
          pos = i;
          found = 1'b1;
        end
      end
      if (pos == n) begin
        if (n >= cap) begin
          tbl_cnt = n;
        end else begin
          tbl_key[n] = it.key;
          tbl_val[n] = it.value;
          tbl_cnt = n + 1;
          r.accepted = 1'b1;
        end
      end else if (tbl_key[pos] == it.key) begin
        tbl_cnt = n;
      end else begin
        if (n < cap) n++;
        for (int i = n - 1; i > pos; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_val[i] = tbl_val[i-1];
        end
        tbl_key[pos] = it.key;
        tbl_val[pos] = it.value;
        tbl_cnt = n;
        r.accepted = 1'b1;
      end
    end else if (int'(it.index) < tbl_cnt) begin
      r.entry_valid = 1'b1;
      r.entry_key   = tbl_key[it.index];
      r.entry_value = tbl_val[it.index];
    end
    r.count = CNT_W'(tbl_cnt);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= 100) begin
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        topk_expect_q.push_back(apply_item(tx_item));
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          tx_item = pend_q.pop_front();
          in_tuser  <= tx_item.func;
          in_tdata  <= IN_DATA_W'({tx_item.index, tx_item.value, tx_item.key});
          in_tvalid <= 1'b1;
          tx_gap = tx_gap_en ? $urandom_range(0, 3) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    topk_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (topk_expect_q.size() == 0) begin
          report_mismatch("unexpected transaction", out_tdata[31:0], 32'h0);
        end else begin
          want = topk_expect_q.pop_front();
          if (out_tdata[0] !== want.accepted)
            report_mismatch("accepted", 32'(out_tdata[0]), 32'(want.accepted));
          if (out_tdata[5:1] !== want.count)
            report_mismatch("count", 32'(out_tdata[5:1]), 32'(want.count));
          if (out_tdata[6] !== want.entry_valid)
            report_mismatch("entry_valid", 32'(out_tdata[6]), 32'(want.entry_valid));
          if (out_tdata[38:7] !== want.entry_key)
            report_mismatch("entry_key", out_tdata[38:7], want.entry_key);
          if (out_tdata[70:39] !== want.entry_value)
            report_mismatch("entry_value", out_tdata[70:39], want.entry_value);
        end
        results_seen++;
        if (results_seen == 60 || results_seen == 290) begin
          rx_hold = 40;
        end else begin
          rx_hold = rx_gap_en ? $urandom_range(0, 3) : 0;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic func, input logic [31:0] key,
                            input logic [31:0] value, input logic [IDX_W-1:0] index);
    topk_item_t it;
    it.func  = func;
    it.key   = key;
    it.value = value;
    it.index = index;
    pend_q.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random();
    logic        func;
    logic [31:0] key;
    int unsigned sel;
    func = ($urandom_range(0, 99) < 65) ? FUNC_PUSH : FUNC_READ;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      key = 32'($urandom_range(0, 40)) - 32'd20;
    end else if (sel < 7) begin
      case ($urandom_range(0, 3))
        0:       key = 32'h8000_0000;
        1:       key = 32'h7fff_ffff;
        2:       key = 32'hffff_ffff;
        default: key = 32'h0;
      endcase
    end else begin
      key = $urandom;
    end
    queue_item(func, key, $urandom, IDX_W'($urandom_range(0, 15)));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || topk_expect_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    if (addr == CFG_DESCENDING) begin
      order_desc = data[0];
      tbl_cnt = 0;
    end else begin
      cap_reg = data;
      if (tbl_cnt > eff_cap()) tbl_cnt = eff_cap();
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int caps [6];
    caps = '{4, 1, 16, 0, 31, 7};
    for (int i = 0; i < DEPTH; i++) begin
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // ascending, full capacity: empty reads, key 0, duplicates, extremes
    queue_item(FUNC_READ, $urandom, $urandom, 4'd0);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd15);
    queue_item(FUNC_PUSH, 32'h0, 32'h7fff_ffff, 4'd0);
    queue_item(FUNC_PUSH, 32'h0, 32'hffff_ffff, 4'd15);
    queue_item(FUNC_PUSH, 32'h8000_0000, 32'h8000_0000, 4'd5);
    queue_item(FUNC_PUSH, 32'h7fff_ffff, 32'h0, 4'd10);
    queue_item(FUNC_PUSH, 32'hffff_ffff, 32'h1, 4'd3);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd0);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd1);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd3);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd4);
    wait_drained();

    // lower capacity under the count: tail dropped, full-table rejects
    write_reg(CFG_CAPACITY, 5'd2);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd1);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd2);
    queue_item(FUNC_PUSH, 32'h7fff_ffff, $urandom, 4'd0);
    queue_item(FUNC_PUSH, 32'h8000_0000, $urandom, 4'd0);
    queue_item(FUNC_PUSH, 32'hffff_fffb, 32'h55, 4'd0);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd1);
    wait_drained();

    // capacity zero behaves as one
    write_reg(CFG_CAPACITY, 5'd0);
    queue_item(FUNC_PUSH, 32'h8000_0001, $urandom, 4'd0);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd0);
    wait_drained();

    // capacity above depth, then descending order empties the table
    write_reg(CFG_CAPACITY, 5'd31);
    write_reg(CFG_DESCENDING, 5'd1);
    queue_item(FUNC_PUSH, 32'd5, $urandom, 4'd0);
    queue_item(FUNC_PUSH, 32'hffff_fffd, $urandom, 4'd0);
    queue_item(FUNC_PUSH, 32'h7fff_ffff, $urandom, 4'd0);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd0);
    queue_item(FUNC_READ, $urandom, $urandom, 4'd2);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      tx_gap_en = (p != 2);
      rx_gap_en = (p != 2 && p != 4);
      if (p % 2 == 0) write_reg(CFG_DESCENDING, (p != 0) ? 5'd1 : 5'd0);
      write_reg(CFG_CAPACITY, CFG_DATA_W'(caps[p]));
      @(negedge clk);
      repeat (72) queue_random();
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
